[design/tsan_pkg.sv]
package tsan_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int THRESH_W = 25;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 25;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 25'd200;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 8'd8;

    localparam logic REG_SWIPE_THRESHOLD = 1'b0;
    localparam logic REG_IMAGE_COUNT     = 1'b1;

    localparam logic [4:0]  EV_KEY       = 5'd1;
    localparam logic [4:0]  EV_ABS       = 5'd3;
    localparam logic [9:0]  CODE_X       = 10'd0;
    localparam logic [9:0]  CODE_Y       = 10'd1;
    localparam logic [9:0]  CODE_TOUCH   = 10'd330;
    localparam logic [11:0] BTN_RELEASE  = 12'd0;
    localparam logic [11:0] BTN_PRESS    = 12'd1;

    // x * 800 / 1024 == x * 25 >> 5
    localparam logic [16:0] X_MUL   = 17'd25;
    // (4 * y) / 5 via reciprocal, exact for 14-bit operands
    localparam logic [15:0] Y_RECIP = 16'd52429;

    // exit corner on the start point
    localparam logic signed [12:0] EXIT_X_LO = 13'sd700;
    localparam logic signed [12:0] EXIT_X_HI = 13'sd800;
    localparam logic signed [12:0] EXIT_Y_HI = 13'sd100;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_LEFT  = 2'd1,
        GEST_RIGHT = 2'd2,
        GEST_EXIT  = 2'd3
    } gesture_t;

    typedef struct packed {
        logic [4:0]  event_type;
        logic [9:0]  event_code;
        logic [11:0] event_value;
    } in_word_t;

    typedef struct packed {
        gesture_t    gesture;
        logic [7:0]  image_index;
    } out_word_t;

    typedef struct packed {
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic               corner;
    } move_t;

endpackage

[design/touch_swipe_album_navigator.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | in_word  (event_type, event_code, event_value)
// out      | out_valid / out_ready| out_word (gesture, image_index)
// cfg      | cfg_we               | cfg_addr, cfg_wdata
//
// One word per cycle sustained while the queue is not full. An accepted release is
// held in turn by the queue entry, the square stage and the classify/output register.
// in_ready drops only when the QUEUE_DEPTH-entry queue between front and back is full.
// Reset is asynchronous, active low; no clearing pass.
module touch_swipe_album_navigator #(
    parameter int QUEUE_DEPTH = tsan_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tsan_pkg::in_word_t         in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tsan_pkg::out_word_t        out_word,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [tsan_pkg::CFG_W-1:0] cfg_wdata
);
    import tsan_pkg::*;

    logic [THRESH_W-1:0] swipe_threshold_reg, swipe_threshold_next;
    logic [COUNT_W-1:0]  image_count_reg, image_count_next;

    logic  push;
    move_t push_word;
    logic  full;
    logic  pop;
    logic  q_valid;
    move_t pop_word;

    always_comb
    begin
        swipe_threshold_next = swipe_threshold_reg;
        image_count_next     = image_count_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SWIPE_THRESHOLD: swipe_threshold_next = cfg_wdata[THRESH_W-1:0];
                REG_IMAGE_COUNT:     image_count_next     = cfg_wdata[COUNT_W-1:0];
                default:             image_count_next     = image_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swipe_threshold_reg <= THRESH_RESET;
            image_count_reg     <= COUNT_RESET;
        end
        else
        begin
            swipe_threshold_reg <= swipe_threshold_next;
            image_count_reg     <= image_count_next;
        end
    end

    tsan_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .push      (push),
        .push_word (push_word),
        .full      (full)
    );

    tsan_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_word  (pop_word)
    );

    tsan_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .pop             (pop),
        .pop_word        (pop_word),
        .swipe_threshold (swipe_threshold_reg),
        .image_count     (image_count_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_word        (out_word)
    );

endmodule

[design/tsan_front.sv]
module tsan_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsan_pkg::in_word_t in_word,
    output logic              push,
    output tsan_pkg::move_t   push_word,
    input  logic              full
);
    import tsan_pkg::*;

    logic [11:0]        last_x_reg, last_x_next;
    logic [11:0]        last_y_reg, last_y_next;
    logic signed [12:0] press_x_reg, press_x_next;
    logic signed [12:0] press_y_reg, press_y_next;

    logic        accept;
    logic [16:0] x_prod;
    logic [29:0] y_prod;
    logic        is_abs;
    logic        is_touch;
    logic        release_ev;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    assign x_prod = {5'd0, in_word.event_value} * X_MUL;
    assign y_prod = {2'd0, in_word.event_value, 2'b00} * {14'd0, Y_RECIP};

    assign is_abs     = (in_word.event_type == EV_ABS);
    assign is_touch   = (in_word.event_type == EV_KEY) && (in_word.event_code == CODE_TOUCH);
    assign release_ev = is_touch && (in_word.event_value == BTN_RELEASE);

    assign push = accept && release_ev;

    always_comb
    begin
        push_word.dx     = $signed({1'b0, last_x_reg}) - press_x_reg;
        push_word.dy     = $signed({1'b0, last_y_reg}) - press_y_reg;
        push_word.corner = (press_x_reg >= EXIT_X_LO) && (press_x_reg < EXIT_X_HI)
                        && (press_y_reg >= 13'sd0) && (press_y_reg < EXIT_Y_HI);
    end

    always_comb
    begin
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        press_x_next = press_x_reg;
        press_y_next = press_y_reg;
        if (accept)
        begin
            if (is_abs && in_word.event_code == CODE_X)
            begin
                last_x_next = x_prod[16:5];
            end
            else if (is_abs && in_word.event_code == CODE_Y)
            begin
                last_y_next = y_prod[29:18];
            end
            else if (is_touch && in_word.event_value == BTN_PRESS)
            begin
                press_x_next = $signed({1'b0, last_x_reg});
                press_y_next = $signed({1'b0, last_y_reg});
            end
            else if (release_ev)
            begin
                press_x_next = '1;
                press_y_next = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            press_x_reg <= '1;
            press_y_reg <= '1;
        end
        else
        begin
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            press_x_reg <= press_x_next;
            press_y_reg <= press_y_next;
        end
    end

endmodule

[design/tsan_fifo.sv]
module tsan_fifo #(
    parameter int DEPTH = tsan_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsan_pkg::move_t push_word,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tsan_pkg::move_t pop_word
);
    import tsan_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    move_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/tsan_back.sv]
module tsan_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          pop,
    input  tsan_pkg::move_t               pop_word,
    input  logic [tsan_pkg::THRESH_W-1:0] swipe_threshold,
    input  logic [tsan_pkg::COUNT_W-1:0]  image_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tsan_pkg::out_word_t           out_word
);
    import tsan_pkg::*;

    // stage A: squares and direction tests
    logic        a_valid_reg, a_valid_next;
    logic [23:0] sq_x_reg, sq_y_reg;
    logic        wider_reg, left_reg, corner_reg;

    // stage B: classify and step index into output register
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg;
    logic [7:0]        index_reg, index_next;

    logic        a_load;
    logic        b_fire;
    logic [25:0] sq_x_full, sq_y_full;
    logic [11:0] abs_x, abs_y;
    logic [24:0] travel;
    logic        swipe;
    gesture_t    gesture;
    logic [7:0]  count;
    logic [8:0]  index_inc;

    assign b_fire = a_valid_reg && (!out_valid_reg || out_ready);
    assign a_load = q_valid && (!a_valid_reg || b_fire);
    assign pop    = a_load;

    assign sq_x_full = 26'(pop_word.dx * pop_word.dx);
    assign sq_y_full = 26'(pop_word.dy * pop_word.dy);
    assign abs_x     = pop_word.dx[12] ? 12'(-pop_word.dx) : pop_word.dx[11:0];
    assign abs_y     = pop_word.dy[12] ? 12'(-pop_word.dy) : pop_word.dy[11:0];

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_load)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            sq_x_reg   <= sq_x_full[23:0];
            sq_y_reg   <= sq_y_full[23:0];
            wider_reg  <= (abs_x > abs_y);
            left_reg   <= pop_word.dx[12];
            corner_reg <= pop_word.corner;
        end
    end

    assign travel    = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign swipe     = (travel >= swipe_threshold) && wider_reg;
    assign count     = (image_count == '0) ? 8'd1 : image_count;
    assign index_inc = {1'b0, index_reg} + 9'd1;

    always_comb
    begin
        if (swipe)
        begin
            gesture = left_reg ? GEST_LEFT : GEST_RIGHT;
        end
        else if (corner_reg)
        begin
            gesture = GEST_EXIT;
        end
        else
        begin
            gesture = GEST_NONE;
        end
    end

    always_comb
    begin
        index_next     = index_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (b_fire)
        begin
            out_valid_next = 1'b1;
            case (gesture)
                GEST_LEFT:
                begin
                    index_next = (index_inc >= {1'b0, count}) ? 8'd0 : index_inc[7:0];
                end
                GEST_RIGHT:
                begin
                    index_next = (index_reg == 8'd0) ? count - 8'd1 : index_reg - 8'd1;
                end
                default:
                begin
                    index_next = index_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            out_word_reg.gesture     <= gesture;
            out_word_reg.image_index <= index_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            index_reg     <= index_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
